>>> rtl/core/rau_pkg.sv
package rau_pkg;

    localparam int OP_W  = 16;
    localparam int NUM_W = 2 * OP_W + 1;
    localparam int DEN_W = 2 * OP_W - 1;
    localparam int MAG_W = 2 * OP_W;
    localparam int CNT_W = $clog2(MAG_W);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]             cmd;
        logic signed [OP_W-1:0] a_num;
        logic signed [OP_W-1:0] a_den;
        logic signed [OP_W-1:0] b_num;
        logic signed [OP_W-1:0] b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    zero_den_error;
    } rau_out_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul;
        logic [1:0] mul_sel;
        logic       comb;
        logic       gcd_init;
        logic       strip;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } rau_ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic d_zero;
        logic strip_done;
        logic gcd_done;
    } rau_sts_t;

    // magnitude of a two's complement operand, exact for the most negative value
    function automatic logic [OP_W-1:0] mag_of(input logic [OP_W-1:0] v);
        mag_of = v[OP_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

>>> rtl/core/rau_datapath.sv
module rau_datapath (
    input  logic              clk,
    input  rau_pkg::rau_in_t  in_data,
    input  rau_pkg::rau_ctl_t ctl,
    output rau_pkg::rau_sts_t sts,
    output rau_pkg::rau_out_t out_data
);
    import rau_pkg::*;

    logic [1:0]      cmd_reg;
    logic            an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [OP_W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [MAG_W-1:0] pa_reg, pb_reg, n_mag_reg;
    logic            pa_neg_reg, pb_neg_reg, n_neg_reg, d_neg_reg;
    logic [DEN_W-1:0] d_mag_reg;
    logic [MAG_W-1:0] x_reg, y_reg, dvs_reg;
    logic [CNT_W-1:0] k_reg;
    logic [MAG_W-1:0] qn_reg, qd_reg, rn_reg, rd_reg;
    rau_out_t         out_reg;

    logic [OP_W-1:0]  mx, my;
    logic             mneg;
    logic [MAG_W-1:0] prod;
    logic [MAG_W:0]   tn, td;
    logic [NUM_W-1:0] qn_ext;
    logic             res_neg;

    // select multiplier operands for this step
    always_comb
    begin
        mx = ad_reg;
        my = bd_reg;
        mneg = ad_neg_reg ^ bd_neg_reg;
        case (ctl.mul_sel)
            2'd0:
            begin
                mx = ad_reg;
                my = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
                mneg = ad_neg_reg ^ ((cmd_reg == CMD_DIV) ? bn_neg_reg : bd_neg_reg);
            end
            2'd1:
            begin
                mx = an_reg;
                my = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
                mneg = an_neg_reg ^ ((cmd_reg == CMD_MUL) ? bn_neg_reg : bd_neg_reg);
            end
            default:
            begin
                mx = ad_reg;
                my = bn_reg;
                mneg = ad_neg_reg ^ bn_neg_reg ^ (cmd_reg == CMD_SUB);
            end
        endcase
        prod = mx * my;
    end

    // restoring division trial subtracts
    assign tn = {rn_reg, qn_reg[MAG_W-1]};
    assign td = {rd_reg, qd_reg[MAG_W-1]};

    assign sts.d_zero     = (d_mag_reg == '0);
    assign sts.strip_done = (x_reg == '0) || x_reg[0] || y_reg[0];
    assign sts.gcd_done   = (x_reg == '0);

    assign qn_ext  = {1'b0, qn_reg};
    assign res_neg = (n_neg_reg != d_neg_reg) && (qn_reg != '0);

    always_ff @(posedge clk)
    begin
        // latch operands as sign and magnitude
        if (ctl.load)
        begin
            cmd_reg    <= in_data.cmd;
            an_neg_reg <= in_data.a_num[OP_W-1];
            ad_neg_reg <= in_data.a_den[OP_W-1];
            bn_neg_reg <= in_data.b_num[OP_W-1];
            bd_neg_reg <= in_data.b_den[OP_W-1];
            an_reg     <= mag_of(in_data.a_num);
            ad_reg     <= mag_of(in_data.a_den);
            bn_reg     <= mag_of(in_data.b_num);
            bd_reg     <= mag_of(in_data.b_den);
        end

        // capture products
        if (ctl.mul)
        begin
            case (ctl.mul_sel)
                2'd0:
                begin
                    d_mag_reg <= prod[DEN_W-1:0];
                    d_neg_reg <= mneg;
                end
                2'd1:
                begin
                    pa_reg     <= prod;
                    pa_neg_reg <= mneg;
                end
                default:
                begin
                    pb_reg     <= cmd_reg[1] ? '0 : prod;
                    pb_neg_reg <= cmd_reg[1] ? pa_neg_reg : mneg;
                end
            endcase
        end

        // signed magnitude sum of the cross products
        if (ctl.comb)
        begin
            if (pa_neg_reg == pb_neg_reg)
            begin
                n_mag_reg <= pa_reg + pb_reg;
                n_neg_reg <= pa_neg_reg;
            end
            else if (pa_reg >= pb_reg)
            begin
                n_mag_reg <= pa_reg - pb_reg;
                n_neg_reg <= pa_neg_reg;
            end
            else
            begin
                n_mag_reg <= pb_reg - pa_reg;
                n_neg_reg <= pb_neg_reg;
            end
        end

        // binary gcd
        if (ctl.gcd_init)
        begin
            x_reg <= n_mag_reg;
            y_reg <= {1'b0, d_mag_reg};
            k_reg <= '0;
        end
        else if (ctl.strip)
        begin
            x_reg <= x_reg >> 1;
            y_reg <= y_reg >> 1;
            k_reg <= k_reg + 1'b1;
        end
        else if (ctl.gcd_step)
        begin
            if (!x_reg[0])
                x_reg <= x_reg >> 1;
            else if (!y_reg[0])
                y_reg <= y_reg >> 1;
            else if (x_reg >= y_reg)
                x_reg <= x_reg - y_reg;
            else
                y_reg <= y_reg - x_reg;
        end

        // divide numerator and denominator by the gcd, one bit a cycle
        if (ctl.div_init)
        begin
            dvs_reg <= y_reg << k_reg;
            qn_reg  <= n_mag_reg;
            qd_reg  <= {1'b0, d_mag_reg};
            rn_reg  <= '0;
            rd_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            if (tn >= {1'b0, dvs_reg})
            begin
                rn_reg <= MAG_W'(tn - {1'b0, dvs_reg});
                qn_reg <= {qn_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= tn[MAG_W-1:0];
                qn_reg <= {qn_reg[MAG_W-2:0], 1'b0};
            end
            if (td >= {1'b0, dvs_reg})
            begin
                rd_reg <= MAG_W'(td - {1'b0, dvs_reg});
                qd_reg <= {qd_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= td[MAG_W-1:0];
                qd_reg <= {qd_reg[MAG_W-2:0], 1'b0};
            end
        end

        // format the result item
        if (ctl.out_load)
        begin
            if (d_mag_reg == '0)
            begin
                out_reg.res_num        <= '0;
                out_reg.res_den        <= '0;
                out_reg.zero_den_error <= 1'b1;
            end
            else
            begin
                out_reg.res_num        <= res_neg ? (~qn_ext + 1'b1) : qn_ext;
                out_reg.res_den        <= qd_reg[DEN_W-1:0];
                out_reg.zero_den_error <= 1'b0;
            end
        end
    end

    assign out_data = out_reg;

endmodule

>>> rtl/core/rau_ctrl.sv
module rau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rau_pkg::rau_sts_t sts,
    output rau_pkg::rau_ctl_t ctl
);
    import rau_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_COMB  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_STRIP = 3'd4;
    localparam logic [2:0] S_GCD   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // sequence the item through multiply, reduce and divide
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        ctl.mul_sel    = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctl.mul = 1'b1;
                if (cnt_reg == CNT_W'(2))
                    state_next = S_COMB;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_COMB:
            begin
                ctl.comb   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.d_zero)
                    state_next = S_OUT;
                else
                begin
                    ctl.gcd_init = 1'b1;
                    state_next   = S_STRIP;
                end
            end
            S_STRIP:
            begin
                if (sts.strip_done)
                    state_next = S_GCD;
                else
                    ctl.strip = 1'b1;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    ctl.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                    ctl.gcd_step = 1'b1;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                    state_next = S_OUT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/rational_arith_unit.sv
// Exact arithmetic on two signed 16-bit fractions with gcd reduction.
// Input channel (in_valid/in_ready/in_data) carries one item: operation code
// and the two fractions. Output channel (out_valid/out_ready/out_data) returns
// one item per input: reduced numerator carrying the sign, positive reduced
// denominator, and an error flag for a zero raw denominator (fields zero).
// One item is worked at a time. The gcd first strips common factors of two
// (at most 30), then runs a shared binary gcd loop (one shift or subtract a
// cycle); a bit-serial divider then forms both reduced quotients together,
// one bit a cycle. A zero raw denominator skips the gcd and the divider.
// The next item can be accepted in the cycle after a result is loaded.
// Three cross products go through one 16x16 multiplier in turn.
// A finished item sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the block finishes the next item
// and then holds in_ready low until the output register is taken.
// Reset returns the controller to idle and drops out_valid.
module rational_arith_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rau_pkg::rau_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rau_pkg::rau_out_t out_data
);
    import rau_pkg::*;

    rau_ctl_t ctl;
    rau_sts_t sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    rau_datapath u_datapath (
        .clk      (clk),
        .in_data  (in_data),
        .ctl      (ctl),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

>>> rtl/core/rau_checker.sv
module rau_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input rau_pkg::rau_out_t out_data
);
    import rau_pkg::*;

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in work");

    // error result carries zero fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_den_error |->
            out_data.res_num == '0 && out_data.res_den == '0)
        else $error("error item with nonzero fields");

    // good result has a positive denominator
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.zero_den_error |-> out_data.res_den != '0)
        else $error("zero denominator without error");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
